// ----- design/tab_to_space_expander_unit_assert.svh -----
// Assertion helpers included by tab_to_space_expander_unit.sv.
`ifndef TAB_TO_SPACE_EXPANDER_UNIT_ASSERT_SVH
`define TAB_TO_SPACE_EXPANDER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define TSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tse_pkg.sv -----
package tse_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [7:0]  stop_idx_t;
	typedef logic [15:0] col16_t;
	typedef logic [9:0]  tab_width_t;
	typedef logic [8:0]  stop_count_t;
	typedef logic [3:0]  paddr_t;
	typedef logic [31:0] apb_data_t;
	typedef logic [1:0]  reg_idx_t;

	localparam byte_t CH_TAB = 8'h09;
	localparam byte_t CH_BS  = 8'h08;
	localparam byte_t CH_NL  = 8'h0A;
	localparam byte_t CH_SP  = 8'h20;

	// register index, taken from paddr[3:2]
	localparam reg_idx_t REG_TAB_WIDTH    = 2'd0;
	localparam reg_idx_t REG_STOP_COUNT   = 2'd1;
	localparam reg_idx_t REG_LEADING_ONLY = 2'd2;

	localparam tab_width_t TAB_WIDTH_RST = 10'd8;

	localparam logic MODE_TEXT = 1'b0;
	localparam logic MODE_STOP = 1'b1;

endpackage

// ----- design/tse_stream_if.sv -----
interface tse_item_if;
	import tse_pkg::*;

	logic      valid;
	logic      ready;
	logic      mode;
	byte_t     data_byte;
	stop_idx_t stop_index;
	col16_t    stop_column;

	modport source (output valid, output mode, output data_byte, output stop_index,
		output stop_column, input ready);
	modport sink (input valid, input mode, input data_byte, input stop_index,
		input stop_column, output ready);
endinterface

interface tse_result_if;
	import tse_pkg::*;

	logic   valid;
	logic   ready;
	byte_t  out_byte;
	col16_t repeat_count;
	col16_t column_after;

	modport source (output valid, output out_byte, output repeat_count,
		output column_after, input ready);
	modport sink (input valid, input out_byte, input repeat_count,
		input column_after, output ready);
endinterface

// ----- design/tab_to_space_expander_unit.sv -----
// Channel  Dir  Payload                                         Accepted when
// item     in   mode, data_byte, stop_index, stop_column        valid && ready
// result   out  out_byte, repeat_count, column_after            valid && ready
// apb      in   tab_width, stop_count, leading_only registers   psel && penable && pwrite
//
// Stop-table write: stored when the item is accepted. Plain byte: accept, then result load.
// Tab with uniform stops: accept, the 1-bit-per-cycle remainder loop, then result load.
// Tab with explicit stops: accept, a scan of at most min(stop_count, MAX_STOPS) entries
// through the single read port of the stop-table memory, one entry per cycle, then result load.
// A held result stalls only the final load; reset clears column to 0, sets leading blanks,
// and loads register defaults; the stop table needs no clearing pass.
`include "tab_to_space_expander_unit_assert.svh"

module tab_to_space_expander_unit #(
	parameter int MAX_STOPS   = 256,
	parameter int COLUMN_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	tse_item_if.sink           item,
	tse_result_if.source       result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  tse_pkg::paddr_t    paddr,
	input  tse_pkg::apb_data_t pwdata,
	output tse_pkg::apb_data_t prdata,
	output logic               pready
);
	import tse_pkg::*;

	localparam int AW   = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
	localparam int NW   = $clog2(MAX_STOPS + 1);
	localparam int CMPW = (NW > 9) ? NW : 9;
	localparam int CW   = (COLUMN_BITS > 16) ? COLUMN_BITS : 16;
	localparam int NXW  = CW + 1;
	localparam int DCW  = $clog2(COLUMN_BITS);
	localparam logic [NXW-1:0] COL_MAX_NX = (NXW'(1) << COLUMN_BITS) - NXW'(1);

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_SCAN, S_FIN} state_t;
	typedef logic [COLUMN_BITS-1:0] col_t;

	// configuration registers
	tab_width_t  tab_width_q;
	stop_count_t stop_count_q;
	logic        leading_only_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_width_q    <= TAB_WIDTH_RST;
			stop_count_q   <= '0;
			leading_only_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_TAB_WIDTH:    tab_width_q    <= pwdata[9:0];
				REG_STOP_COUNT:   stop_count_q   <= pwdata[8:0];
				REG_LEADING_ONLY: leading_only_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_TAB_WIDTH:    prdata = 32'(tab_width_q);
			REG_STOP_COUNT:   prdata = 32'(stop_count_q);
			REG_LEADING_ONLY: prdata = 32'(leading_only_q);
			default:          prdata = '0;
		endcase
	end

	// control and datapath state
	state_t          state_q;
	col_t            col_q;
	logic            lead_q;
	byte_t           byte_q;
	col16_t          rep_q;
	col_t            dvd_q;
	logic [9:0]      rem_q;
	logic [DCW-1:0]  div_cnt_q;
	logic [NW-1:0]   scan_q;
	logic            pend_q;
	logic            res_valid_q;
	byte_t           res_byte_q;
	col16_t          res_rep_q;
	col16_t          res_col_q;

	// stop table
	col16_t stop_mem [MAX_STOPS];
	col16_t rd_data_q;
	logic [AW-1:0] rd_addr;
	logic item_acc, stop_wr;

	assign item.ready = (state_q == S_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign stop_wr    = item_acc && (item.mode == MODE_STOP) &&
		(32'(item.stop_index) < 32'(MAX_STOPS));
	assign rd_addr    = scan_q[AW-1:0];

	// writes only in idle, reads only consumed while scanning: no same-entry overlap
	always_ff @(posedge clk) begin
		if (stop_wr)
			stop_mem[AW'(item.stop_index)] <= item.stop_column;
		rd_data_q <= stop_mem[rd_addr];
	end

	// effective stop count and tab width
	logic [NW-1:0] n_eff;
	logic          explicit_mode;
	tab_width_t    w_eff;

	assign n_eff = (CMPW'(stop_count_q) > CMPW'(MAX_STOPS)) ? NW'(MAX_STOPS)
		: NW'(stop_count_q);
	assign explicit_mode = (n_eff >= NW'(2));
	assign w_eff = (tab_width_q == '0) ? tab_width_t'(1) : tab_width_q;

	// restoring remainder step
	logic [10:0] rem_sh, rem_sub;
	logic [9:0]  rem_nx;
	assign rem_sh  = {rem_q, dvd_q[COLUMN_BITS-1]};
	assign rem_sub = rem_sh - {1'b0, w_eff};
	assign rem_nx  = (rem_sh >= {1'b0, w_eff}) ? rem_sub[9:0] : rem_sh[9:0];

	// table scan compare
	logic [CW-1:0] stop_cw, col_cw, stop_diff;
	logic          stop_hit;
	assign stop_cw   = CW'(rd_data_q);
	assign col_cw    = CW'(col_q);
	assign stop_hit  = pend_q && (stop_cw > col_cw);
	assign stop_diff = stop_cw - col_cw;

	// result formation
	logic [NXW-1:0] nx_w, nx_sat;
	col_t           col_new;
	logic           lead_new;
	byte_t          ob;
	col16_t         rep_out;
	logic [CW-1:0]  col_new_cw;
	col16_t         col_out;
	logic           out_free;

	assign nx_w   = NXW'(col_q) + NXW'(rep_q);
	assign nx_sat = (nx_w > COL_MAX_NX) ? COL_MAX_NX : nx_w;

	always_comb begin
		col_new  = col_q;
		lead_new = lead_q;
		ob       = byte_q;
		rep_out  = 16'd1;
		case (byte_q)
			CH_TAB: begin
				col_new = nx_sat[COLUMN_BITS-1:0];
				if (leading_only_q && !lead_q) begin
					ob = CH_TAB;
				end else begin
					ob      = CH_SP;
					rep_out = rep_q;
				end
			end
			CH_BS: begin
				if (col_q != '0)
					col_new = col_q - col_t'(1);
				lead_new = 1'b0;
			end
			CH_NL: begin
				col_new  = '0;
				lead_new = 1'b1;
			end
			default: begin
				col_new = nx_sat[COLUMN_BITS-1:0];
				if (byte_q != CH_SP)
					lead_new = 1'b0;
			end
		endcase
	end

	assign col_new_cw = CW'(col_new);
	assign col_out    = (col_new_cw > CW'(16'hFFFF)) ? 16'hFFFF : col_new_cw[15:0];
	assign out_free   = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			lead_q      <= 1'b1;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
			byte_q      <= '0;
			rep_q       <= '0;
			dvd_q       <= '0;
			rem_q       <= '0;
			div_cnt_q   <= '0;
			scan_q      <= '0;
			res_byte_q  <= '0;
			res_rep_q   <= '0;
			res_col_q   <= '0;
		end else begin
			// in S_FIN a load replaces the departing transaction
			if (res_valid_q && result.ready && state_q != S_FIN)
				res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (item_acc && item.mode == MODE_TEXT) begin
						byte_q    <= item.data_byte;
						rep_q     <= 16'd1;
						dvd_q     <= col_q;
						rem_q     <= '0;
						div_cnt_q <= DCW'(COLUMN_BITS - 1);
						scan_q    <= '0;
						pend_q    <= 1'b0;
						if (item.data_byte != CH_TAB)
							state_q <= S_FIN;
						else if (explicit_mode)
							state_q <= S_SCAN;
						else
							state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q     <= rem_nx;
					dvd_q     <= dvd_q << 1;
					div_cnt_q <= div_cnt_q - DCW'(1);
					if (div_cnt_q == '0) begin
						rep_q   <= 16'(w_eff - rem_nx);
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					if (stop_hit) begin
						rep_q   <= stop_diff[15:0];
						pend_q  <= 1'b0;
						state_q <= S_FIN;
					end else if (scan_q == n_eff) begin
						// ran past the last stop: advance by one
						rep_q   <= 16'd1;
						pend_q  <= 1'b0;
						state_q <= S_FIN;
					end else begin
						scan_q <= scan_q + NW'(1);
						pend_q <= 1'b1;
					end
				end
				S_FIN: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_byte_q  <= ob;
						res_rep_q   <= rep_out;
						res_col_q   <= col_out;
						col_q       <= col_new;
						lead_q      <= lead_new;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid        = res_valid_q;
	assign result.out_byte     = res_byte_q;
	assign result.repeat_count = res_rep_q;
	assign result.column_after = res_col_q;

	`TSE_ASSERT_NOW(a_rep_nonzero, clk, arst_n, state_q == S_FIN, rep_q != '0,
		"zero tab distance at result load")
	`TSE_ASSERT_NOW(a_pend_in_scan, clk, arst_n, pend_q, state_q == S_SCAN,
		"table read pending outside scan")
	`TSE_ASSERT_NEXT(a_text_busy, clk, arst_n, item_acc && item.mode == MODE_TEXT,
		state_q != S_IDLE, "text transaction did not start work")
	`TSE_ASSERT_NEXT(a_newline_reset, clk, arst_n,
		state_q == S_FIN && out_free && byte_q == CH_NL,
		col_q == '0 && lead_q && res_valid_q, "newline did not reset column")

endmodule

// ----- tb/sv/tse_expansion_checker.sv -----
`timescale 1ns / 1ps

module tse_expansion_checker #(
	parameter int MAX_STOPS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	tse_item_if                item,
	tse_result_if              result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  tse_pkg::paddr_t    paddr,
	input  tse_pkg::apb_data_t pwdata,
	output int                 mismatches,
	output int                 outstanding,
	output int                 results_seen
);
	import tse_pkg::*;

	localparam int unsigned COL_MAX = 32'h0000_FFFF;

	typedef struct packed {
		byte_t  out_byte;
		col16_t repeat_count;
		col16_t column_after;
	} run_t;

	run_t        expected_runs[$];
	tab_width_t  tab_width;
	stop_count_t stop_count;
	logic        leading_only;
	int unsigned column;
	logic        in_leading;
	col16_t      stop_table [MAX_STOPS];

	int n_mismatch = 0;
	int n_pending  = 0;
	int n_results  = 0;

	assign mismatches   = n_mismatch;
	assign outstanding  = n_pending;
	assign results_seen = n_results;

	function automatic int unsigned next_tab_stop(int unsigned col);
		int unsigned n;
		int unsigned w;
		n = (stop_count > MAX_STOPS) ? MAX_STOPS : stop_count;
		if (n >= 2) begin
			// first table entry past the column, in table order
			for (int unsigned i = 0; i < n; i++)
				if (stop_table[i] > col)
					return stop_table[i];
			return col + 1;
		end
		w = (tab_width == '0) ? 1 : tab_width;
		return col + (w - col % w);
	endfunction

	task automatic predict_text(input byte_t c);
		run_t        run;
		int unsigned nx;
		run.out_byte     = c;
		run.repeat_count = 16'd1;
		case (c)
			CH_TAB: begin
				nx = next_tab_stop(column);
				if (leading_only && !in_leading) begin
					run.out_byte = CH_TAB;
				end else begin
					run.out_byte     = CH_SP;
					run.repeat_count = col16_t'((nx - column > COL_MAX) ? COL_MAX : nx - column);
				end
				column = (nx > COL_MAX) ? COL_MAX : nx;
			end
			CH_BS: begin
				if (column > 0)
					column--;
				in_leading = 1'b0;
			end
			CH_NL: begin
				column     = 0;
				in_leading = 1'b1;
			end
			default: begin
				if (c != CH_SP)
					in_leading = 1'b0;
				column = (column + 1 > COL_MAX) ? COL_MAX : column + 1;
			end
		endcase
		run.column_after = col16_t'(column);
		expected_runs.push_back(run);
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		run_t want;
		if (!arst_n) begin
			tab_width    = TAB_WIDTH_RST;
			stop_count   = '0;
			leading_only = 1'b0;
			column       = 0;
			in_leading   = 1'b1;
			expected_runs.delete();
		end else begin
			// results first: a result never belongs to an item taken at the same edge
			if (result.valid && result.ready) begin
				n_results++;
				if (expected_runs.size() == 0) begin
					$error("unexpected result transaction: out_byte %0h repeat_count %0d",
						result.out_byte, result.repeat_count);
					n_mismatch++;
				end else begin
					want = expected_runs.pop_front();
					if (result.out_byte !== want.out_byte) begin
						$error("out_byte: expected %0h, actual %0h",
							want.out_byte, result.out_byte);
						n_mismatch++;
					end
					if (result.repeat_count !== want.repeat_count) begin
						$error("repeat_count: expected %0d, actual %0d",
							want.repeat_count, result.repeat_count);
						n_mismatch++;
					end
					if (result.column_after !== want.column_after) begin
						$error("column_after: expected %0d, actual %0d",
							want.column_after, result.column_after);
						n_mismatch++;
					end
				end
			end
			if (item.valid && item.ready) begin
				if (item.mode == MODE_STOP) begin
					if (item.stop_index < MAX_STOPS)
						stop_table[item.stop_index] = item.stop_column;
				end else begin
					predict_text(item.data_byte);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_TAB_WIDTH:    tab_width    = pwdata[9:0];
					REG_STOP_COUNT:   stop_count   = pwdata[8:0];
					REG_LEADING_ONLY: leading_only = pwdata[0];
					default: ;
				endcase
			end
		end
		n_pending = expected_runs.size();
	end

endmodule

// ----- tb/sv/tb_tab_to_space_expander_unit.sv -----
`timescale 1ns / 1ps

module tb_tab_to_space_expander_unit;
	import tse_pkg::*;

	typedef struct {
		logic      mode;
		byte_t     data_byte;
		stop_idx_t stop_index;
		col16_t    stop_column;
	} stream_item_t;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 40;
	localparam int HOLD_CYCLES     = 400;
	localparam int SETTLE_CYCLES   = 300;

	logic      clk;
	logic      arst_n;
	logic      psel;
	logic      penable;
	logic      pwrite;
	paddr_t    paddr;
	apb_data_t pwdata;
	apb_data_t prdata;
	logic      pready;

	tse_item_if   item_ch ();
	tse_result_if result_ch ();

	int mismatches;
	int outstanding;
	int results_seen;
	int items_sent = 0;
	int settings   = 0;
	bit send_idle  = 1'b1;
	bit recv_idle  = 1'b1;
	bit hold_req   = 1'b0;

	tab_to_space_expander_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tse_expansion_checker expansion_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item_ch),
		.result       (result_ch),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#20_000_000;
		$display("tb_tab_to_space_expander_unit failed");
		$finish;
	end

	function automatic stream_item_t text_item(byte_t c);
		stream_item_t it;
		it.mode        = MODE_TEXT;
		it.data_byte   = c;
		it.stop_index  = stop_idx_t'($urandom);
		it.stop_column = col16_t'($urandom);
		return it;
	endfunction

	function automatic stream_item_t stop_item(int idx, int col);
		stream_item_t it;
		it.mode        = MODE_STOP;
		it.data_byte   = byte_t'($urandom);
		it.stop_index  = stop_idx_t'(idx);
		it.stop_column = col16_t'(col);
		return it;
	endfunction

	function automatic stream_item_t random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			return stop_item($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 160));
		if (pick < 29)
			return text_item(CH_TAB);
		if (pick < 39)
			return text_item(CH_SP);
		if (pick < 47)
			return text_item(CH_NL);
		if (pick < 52)
			return text_item(CH_BS);
		return text_item(byte_t'($urandom_range(0, 255)));
	endfunction

	task automatic apb_write(reg_idx_t idx, apb_data_t value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= paddr_t'({idx, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(int tw, int sc, int lo);
		apb_write(REG_TAB_WIDTH, apb_data_t'(tw));
		apb_write(REG_STOP_COUNT, apb_data_t'(sc));
		apb_write(REG_LEADING_ONLY, apb_data_t'(lo));
		settings++;
	endtask

	task automatic send_item(stream_item_t it);
		int gap;
		gap = send_idle ? $urandom_range(0, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.mode        <= it.mode;
		item_ch.data_byte   <= it.data_byte;
		item_ch.stop_index  <= it.stop_index;
		item_ch.stop_column <= it.stop_column;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
	endtask

	// stop offering, let every result come back, then wait before the next section
	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : receiver
		int gap;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = recv_idle ? $urandom_range(0, 9) : 0;
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	initial begin : stimulus
		int tw;
		int sc;
		int lo;
		item_ch.valid       = 1'b0;
		item_ch.mode        = MODE_TEXT;
		item_ch.data_byte   = '0;
		item_ch.stop_index  = '0;
		item_ch.stop_column = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		@(posedge arst_n);

		// reset settings: uniform stops every 8 columns
		send_item(text_item(CH_TAB));
		send_item(text_item(8'h61));
		send_item(text_item(CH_TAB));
		send_item(text_item(CH_SP));
		send_item(text_item(CH_BS));
		send_item(text_item(CH_NL));
		send_item(text_item(CH_BS));
		send_item(text_item(8'hFF));
		send_item(text_item(8'h00));
		send_item(text_item(CH_NL));
		drain();

		// whole table written before any explicit-stop tab can scan it
		send_idle = 1'b0;
		for (int i = 0; i < 256; i++)
			send_item(stop_item(i, 8 * (i + 1)));
		send_item(stop_item(2, 16'hFFFF));
		send_idle = 1'b1;
		drain();

		// three explicit stops, the last one at the top column: saturation
		configure(1023, 3, 0);
		send_item(text_item(CH_TAB));
		send_item(text_item(CH_TAB));
		send_item(text_item(8'h78));
		send_item(text_item(CH_TAB));
		send_item(text_item(CH_TAB));
		send_item(text_item(8'h79));
		send_item(text_item(CH_BS));
		send_item(text_item(CH_TAB));
		send_item(text_item(CH_NL));
		send_item(stop_item(2, 24));
		drain();

		// zero width acts as one; tab after text passes through
		configure(0, 0, 1);
		send_item(text_item(CH_SP));
		send_item(text_item(CH_TAB));
		send_item(text_item(8'h71));
		send_item(text_item(CH_TAB));
		send_item(text_item(CH_NL));
		send_item(text_item(CH_TAB));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin tw = $urandom_range(1, 16);   sc = 0;                       lo = 0; end
				1: begin tw = $urandom_range(1, 16);   sc = $urandom_range(2, 12);   lo = 1; end
				2: begin tw = 1023;                    sc = 1;        lo = $urandom_range(0, 1); end
				3: begin tw = $urandom_range(0, 1023); sc = 256;                     lo = 0; end
				4: begin tw = 1;                       sc = $urandom_range(257, 511); lo = 1; end
				5: begin tw = 0;                       sc = 0;                       lo = 1; end
				6: begin tw = $urandom_range(0, 1023); sc = $urandom_range(0, 3);
					lo = $urandom_range(0, 1); end
				default: begin tw = 8;                 sc = 2;                       lo = 0; end
			endcase
			configure(tw, sc, lo);
			if (p == 3) begin
				// long receiver stall while items keep coming
				@(posedge clk);
				hold_req = 1'b1;
			end
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (k % 25 == 0) begin
					send_idle = ($urandom_range(0, 3) != 0);
					recv_idle = ($urandom_range(0, 3) != 0);
				end
				send_item(random_item());
			end
			drain();
		end

		$display("%0d item transactions under %0d register settings, %0d result transactions compared",
			items_sent, settings, results_seen);
		$display("uniform and table stops, leading-only tabs, column saturation, long output stall");
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_tab_to_space_expander_unit passed");
		end else begin
			$display("tb_tab_to_space_expander_unit failed");
		end
		$finish;
	end

endmodule
